FILE: rtl/bc1_pkg.sv
// Shared types, constants and helper functions for the BC1 block decoder.
// Depends on nothing; every other file of the decoder imports it.
`default_nettype none

package bc1_pkg;

   localparam int unsigned PixelsPerBlock = 16;
   localparam int unsigned PixelNumWidth = $clog2(PixelsPerBlock);
   localparam int unsigned NumChannels = 3;
   localparam int unsigned PaletteSize = 4;

   // Truncating divide by three of a value below 1024: (x * 683) >> 11.
   localparam logic [9:0] Div3Mul = 10'd683;
   localparam int unsigned Div3Shift = 11;

   localparam logic [PixelNumWidth-1:0] LastPixel = PixelNumWidth'(PixelsPerBlock - 1);

   // Channel 0 is red, channel 1 is green, channel 2 is blue.
   typedef logic [NumChannels-1:0][7:0] rgb_type;

   typedef struct packed {
      rgb_type [PaletteSize-1:0] entry;
      logic [31:0] index_bits;
   } pal_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic rgb_type expand565(input logic [15:0] w);
      rgb_type c;
      c[0] = widen5(w[15:11]);
      c[1] = widen6(w[10:5]);
      c[2] = widen5(w[4:0]);
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bc1_if.sv
// Valid/ready channel interfaces for the block input and the pixel output.
// Depends on bc1_pkg for the pixel number width.
`default_nettype none

interface bc1_req_if;
   logic valid;
   logic ready;
   logic [15:0] color0;
   logic [15:0] color1;
   logic [31:0] index_bits;

   modport source (output valid, color0, color1, index_bits, input ready);
   modport sink (input valid, color0, color1, index_bits, output ready);
endinterface

interface bc1_rsp_if
   import bc1_pkg::*;
;
   logic valid;
   logic ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [PixelNumWidth-1:0] pixel_number;
   logic last;

   modport source (output valid, red, green, blue, pixel_number, last, input ready);
   modport sink (input valid, red, green, blue, pixel_number, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bc1_block_decoder_top.sv
// Top level of the BC1 block decoder: palette pipeline plus pixel serializer
// and output register. Depends on bc1_pkg, bc1_if and bc1_palette.
//
//   Channel   Direction  Payload                                    Transaction
//   req_chan  in         color0, color1, index_bits                 one 8-byte block
//   rsp_chan  out        red, green, blue, pixel_number, last       one pixel
//
// A block reaches the serializer after three pipeline stages; from there its
// pixels pass through the output register onto rsp_chan, one pixel per cycle
// while rsp_chan does not stall. The serializer sets the sustained rate and
// takes the next block as it emits the current block's last pixel.
// Synchronous reset clears only the valid bits and the pixel counter.
// A stall on rsp_chan holds the pixel and backs up the pipeline stage by stage.
`default_nettype none

module bc1_block_decoder_top
   import bc1_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   bc1_req_if.sink req_chan,
   bc1_rsp_if.source rsp_chan
);

   logic pal_valid, pal_ready;
   pal_type pal;

   logic ser_valid_ff, ser_valid_in;
   rgb_type [PaletteSize-1:0] ser_entry_ff;
   logic [31:0] ser_idx_ff, ser_idx_in;
   logic [PixelNumWidth-1:0] ser_count_ff, ser_count_in;
   logic ser_emit, ser_done, ser_load;

   logic rsp_valid_ff, rsp_valid_in;
   rgb_type rsp_pixel_ff;
   logic [PixelNumWidth-1:0] rsp_num_ff;
   logic rsp_last_ff;

   bc1_palette u_palette (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .out_valid(pal_valid),
      .out_ready(pal_ready),
      .out_pal(pal)
   );

   assign ser_emit = ser_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign ser_done = ser_emit && (ser_count_ff == LastPixel);
   assign pal_ready = !ser_valid_ff || ser_done;
   assign ser_load = pal_valid && pal_ready;

   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_idx_in = ser_idx_ff;
      ser_count_in = ser_count_ff;
      if (ser_load) begin
         ser_valid_in = 1'b1;
         ser_idx_in = pal.index_bits;
         ser_count_in = '0;
      end else if (ser_emit) begin
         ser_valid_in = !ser_done;
         ser_idx_in = {2'b00, ser_idx_ff[31:2]};
         ser_count_in = ser_count_ff + 1'b1;
      end
   end

   assign rsp_valid_in = ser_emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         ser_count_ff <= ser_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_idx_ff <= ser_idx_in;
      if (ser_load) begin
         ser_entry_ff <= pal.entry;
      end
      if (ser_emit) begin
         rsp_pixel_ff <= ser_entry_ff[ser_idx_ff[1:0]];
         rsp_num_ff <= ser_count_ff;
         rsp_last_ff <= ser_count_ff == LastPixel;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red = rsp_pixel_ff[0];
   assign rsp_chan.green = rsp_pixel_ff[1];
   assign rsp_chan.blue = rsp_pixel_ff[2];
   assign rsp_chan.pixel_number = rsp_num_ff;
   assign rsp_chan.last = rsp_last_ff;

   a_last_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_last_ff == (rsp_num_ff == LastPixel))
      else $error("Last flag disagrees with the pixel number.");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=>
         rsp_valid_ff && $stable(rsp_pixel_ff) && $stable(rsp_num_ff))
      else $error("Stalled pixel changed before it was taken.");

   a_ser_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(ser_valid_ff) && $past(!reset) |-> $past(ser_count_ff) == LastPixel)
      else $error("Serializer released a block before its final pixel.");

endmodule

`default_nettype wire

FILE: rtl/bc1_palette.sv
// Three-stage palette pipeline: endpoint expansion and sums, divide-by-three
// products, and palette selection. Depends on bc1_pkg and bc1_req_if.
`default_nettype none

module bc1_palette
   import bc1_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   bc1_req_if.sink req,
   output logic out_valid,
   input wire logic out_ready,
   output pal_type out_pal
);

   logic s1_valid_ff, s1_valid_in, s1_ready;
   rgb_type e0_s1_ff, e1_s1_ff, avg_s1_ff;
   logic [NumChannels-1:0][9:0] sum2_s1_ff, sum3_s1_ff;
   logic mode_s1_ff;
   logic [31:0] idx_s1_ff;

   logic s2_valid_ff, s2_valid_in, s2_ready;
   rgb_type e0_s2_ff, e1_s2_ff, avg_s2_ff;
   logic [NumChannels-1:0][19:0] prod2_s2_ff, prod3_s2_ff;
   logic mode_s2_ff;
   logic [31:0] idx_s2_ff;

   logic s3_valid_ff, s3_valid_in, s3_ready;
   pal_type pal_ff, pal_in;

   rgb_type e0_in, e1_in, avg_in;
   logic [NumChannels-1:0][9:0] sum2_in, sum3_in;
   logic [NumChannels-1:0][8:0] sum1_w;
   logic [NumChannels-1:0][19:0] prod2_in, prod3_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   always_comb begin
      e0_in = expand565(req.color0);
      e1_in = expand565(req.color1);
      for (int c = 0; c < NumChannels; c++) begin
         sum2_in[c] = {1'b0, e0_in[c], 1'b0} + {2'b00, e1_in[c]};
         sum3_in[c] = {2'b00, e0_in[c]} + {1'b0, e1_in[c], 1'b0};
         sum1_w[c] = {1'b0, e0_in[c]} + {1'b0, e1_in[c]};
         avg_in[c] = sum1_w[c][8:1];
      end
   end

   always_comb begin
      for (int c = 0; c < NumChannels; c++) begin
         prod2_in[c] = {10'd0, sum2_s1_ff[c]} * {10'd0, Div3Mul};
         prod3_in[c] = {10'd0, sum3_s1_ff[c]} * {10'd0, Div3Mul};
      end
   end

   always_comb begin
      pal_in.entry[0] = e0_s2_ff;
      pal_in.entry[1] = e1_s2_ff;
      pal_in.index_bits = idx_s2_ff;
      for (int c = 0; c < NumChannels; c++) begin
         if (mode_s2_ff) begin
            pal_in.entry[2][c] = prod2_s2_ff[c][Div3Shift +: 8];
            pal_in.entry[3][c] = prod3_s2_ff[c][Div3Shift +: 8];
         end else begin
            pal_in.entry[2][c] = avg_s2_ff[c];
            pal_in.entry[3][c] = 8'd0;
         end
      end
   end

   assign s1_valid_in = s1_ready ? req.valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         e0_s1_ff <= e0_in;
         e1_s1_ff <= e1_in;
         avg_s1_ff <= avg_in;
         sum2_s1_ff <= sum2_in;
         sum3_s1_ff <= sum3_in;
         mode_s1_ff <= req.color0 > req.color1;
         idx_s1_ff <= req.index_bits;
      end
      if (s2_ready) begin
         e0_s2_ff <= e0_s1_ff;
         e1_s2_ff <= e1_s1_ff;
         avg_s2_ff <= avg_s1_ff;
         prod2_s2_ff <= prod2_in;
         prod3_s2_ff <= prod3_in;
         mode_s2_ff <= mode_s1_ff;
         idx_s2_ff <= idx_s1_ff;
      end
      if (s3_ready) begin
         pal_ff <= pal_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_pal = pal_ff;

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> s2_valid_ff)
      else $error("Stage one transaction was dropped on its way to stage two.");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff && $stable(idx_s2_ff))
      else $error("Stalled stage two transaction changed before it moved on.");

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_ready |=> s3_valid_ff && $stable(pal_ff))
      else $error("Stalled palette changed before it was taken.");

endmodule

`default_nettype wire
